### rtl/core/mahs_pkg.sv
package mahs_pkg;

  localparam int BUCKETS_DEF = 64;
  localparam int WAYS_DEF    = 4;
  localparam int ADDR_W      = 48;
  localparam int NBYTES      = ADDR_W / 8;
  localparam int OPC_W       = 2;
  localparam int IDX_W       = 6;
  // Widest byte sum is 6 * 255 = 1530, which fits in 11 bits.
  localparam int SUM_W       = 11;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef logic [ADDR_W-1:0] addr_t;

endpackage

### rtl/core/mac_address_hash_set_top.sv
// MAC address set held in a bucketed table of BUCKETS rows with WAYS ways each.
// Input channel: present in_opcode and in_mac_addr with start high; the transfer
// happens at a rising edge where start is high and busy is low. Opcodes are
// insert, lookup, flush and no operation.
// Result channel: out_strobe is high for exactly one cycle per accepted item,
// with out_hit, out_bucket_full and out_bucket_index valid in that cycle.
// Results come back in the order the items were taken.
// Throughput is one item per cycle; busy is low at all times outside reset.
// The pipeline is input register, bucket hash (byte sum then a reciprocal
// multiply), table row read (after the remainder and its single correction
// step), and compare/write-back.
// A row written by one item is forwarded to the item right behind it, so
// back-to-back operations on the same bucket see each other.
// Reset (synchronous, rst_n low) clears all valid marks and empties the pipeline;
// busy is set at each edge where rst_n is low and cleared at the first edge where
// rst_n is high. A flush clears every valid mark at once. The receiver cannot
// stall, so results are never held back.
module mac_address_hash_set_top #(
  parameter int BUCKETS = mahs_pkg::BUCKETS_DEF,
  parameter int WAYS    = mahs_pkg::WAYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [mahs_pkg::OPC_W-1:0]  in_opcode,
  input  logic [mahs_pkg::ADDR_W-1:0] in_mac_addr,
  output logic                        out_strobe,
  output logic                        out_hit,
  output logic                        out_bucket_full,
  output logic [mahs_pkg::IDX_W-1:0]  out_bucket_index
);

  localparam int SUM_W = mahs_pkg::SUM_W;
  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int EXT_W = (BKT_W > mahs_pkg::IDX_W) ? BKT_W : mahs_pkg::IDX_W;
  localparam int RCP_W = SUM_W + 1;
  localparam int PRD_W = SUM_W + RCP_W;
  localparam int RECIP = (1 << SUM_W) / BUCKETS;
  localparam logic [SUM_W-1:0] BUCKETS_V = SUM_W'(BUCKETS);
  localparam logic [RCP_W-1:0] RECIP_V   = RCP_W'(RECIP);

  typedef logic [WAYS-1:0][mahs_pkg::ADDR_W-1:0] row_t;

  logic busy_r;

  logic              s1_vld_r;
  mahs_pkg::op_t     s1_op_r;
  mahs_pkg::addr_t   s1_addr_r;
  logic [SUM_W-1:0]  byte_sum;
  logic [PRD_W-1:0]  prod;

  logic              s2_vld_r;
  mahs_pkg::op_t     s2_op_r;
  mahs_pkg::addr_t   s2_addr_r;
  logic [SUM_W-1:0]  s2_sum_r;
  logic [SUM_W-1:0]  s2_q_r;
  logic [2*SUM_W-1:0] qb;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  rem_c;
  logic [BKT_W-1:0]  s2_bucket;

  logic              s3_vld_r;
  mahs_pkg::op_t     s3_op_r;
  mahs_pkg::addr_t   s3_addr_r;
  logic [BKT_W-1:0]  s3_bucket_r;

  row_t              mem [BUCKETS];
  row_t              mem_rd_r;
  logic [WAYS-1:0]   valid_r [BUCKETS];

  logic              fwd_vld_r;
  logic [BKT_W-1:0]  fwd_bucket_r;
  row_t              fwd_row_r;

  row_t              row;
  row_t              wr_row;
  logic [WAYS-1:0]   way_vld;
  logic [WAYS-1:0]   match;
  logic [WAYS-1:0]   free_sel;
  logic              full;
  logic              wr_en;
  logic              flush;
  logic              hit_c;
  logic              full_c;
  logic [EXT_W-1:0]  bkt_ext;

  logic                           out_strobe_r;
  logic                           out_hit_r;
  logic                           out_bucket_full_r;
  logic [mahs_pkg::IDX_W-1:0]     out_bucket_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      s1_op_r   <= mahs_pkg::op_t'(in_opcode);
      s1_addr_r <= in_mac_addr;
    end
  end

  // Hash, first half: byte sum and a quotient estimate that is exact or one low.
  always_comb begin
    byte_sum = '0;
    for (int b = 0; b < mahs_pkg::NBYTES; b++) begin
      byte_sum = byte_sum + SUM_W'(s1_addr_r[8*b +: 8]);
    end
  end

  assign prod = PRD_W'(byte_sum) * PRD_W'(RECIP_V);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_op_r   <= s1_op_r;
    s2_addr_r <= s1_addr_r;
    s2_sum_r  <= byte_sum;
    s2_q_r    <= prod[SUM_W +: SUM_W];
  end

  // Hash, second half: remainder with a single correction step.
  assign qb        = (2*SUM_W)'(s2_q_r) * (2*SUM_W)'(BUCKETS_V);
  assign rem       = s2_sum_r - qb[SUM_W-1:0];
  assign rem_c     = (rem >= BUCKETS_V) ? (rem - BUCKETS_V) : rem;
  assign s2_bucket = rem_c[BKT_W-1:0];

  always_ff @(posedge clk) begin
    mem_rd_r <= mem[s2_bucket];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_op_r     <= s2_op_r;
    s3_addr_r   <= s2_addr_r;
    s3_bucket_r <= s2_bucket;
  end

  // The row read in the previous cycle misses a write made by the item just
  // ahead, so that write is forwarded when the buckets agree.
  assign row     = (fwd_vld_r && (fwd_bucket_r == s3_bucket_r)) ? fwd_row_r : mem_rd_r;
  assign way_vld = valid_r[s3_bucket_r];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w]  = (row[w] == s3_addr_r);
    end
  end

  // Lowest free way as a one-hot mask.
  assign free_sel = ~way_vld & (way_vld + WAYS'(1));
  assign full     = &way_vld;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      wr_row[w] = free_sel[w] ? s3_addr_r : row[w];
    end
  end

  assign wr_en  = s3_vld_r && (s3_op_r == mahs_pkg::OP_INSERT) && !full;
  assign flush  = s3_vld_r && (s3_op_r == mahs_pkg::OP_FLUSH);
  assign hit_c  = (s3_op_r == mahs_pkg::OP_LOOKUP) && (|(way_vld & match));
  assign full_c = (s3_op_r == mahs_pkg::OP_INSERT) && full;
  assign bkt_ext = EXT_W'(s3_bucket_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s3_bucket_r] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      for (int i = 0; i < BUCKETS; i++) begin
        valid_r[i] <= '0;
      end
    end else if (wr_en) begin
      valid_r[s3_bucket_r] <= way_vld | free_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else begin
      fwd_vld_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_bucket_r <= s3_bucket_r;
      fwd_row_r    <= wr_row;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r          <= hit_c;
    out_bucket_full_r  <= full_c;
    out_bucket_index_r <= bkt_ext[mahs_pkg::IDX_W-1:0];
  end

  assign busy             = busy_r;
  assign out_strobe       = out_strobe_r;
  assign out_hit          = out_hit_r;
  assign out_bucket_full  = out_bucket_full_r;
  assign out_bucket_index = out_bucket_index_r;

endmodule

### rtl/core/mahs_chk.sv
module mahs_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [mahs_pkg::OPC_W-1:0] in_opcode,
  input logic                       out_strobe,
  input logic                       out_hit,
  input logic                       out_bucket_full
);

  logic acc;

  assign acc = start && !busy;

  // Every transfer yields exactly one result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##4 out_strobe)
    else $error("result missing four cycles after transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(acc, 4))
    else $error("result without a matching transfer");

  // Only an insert can report a full bucket.
  a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_opcode != mahs_pkg::OP_INSERT)) |-> ##4 !out_bucket_full)
    else $error("bucket_full on a non-insert operation");

  // Only a lookup can hit.
  a_hit_only_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_opcode != mahs_pkg::OP_LOOKUP)) |-> ##4 !out_hit)
    else $error("hit on a non-lookup operation");

  // A lookup directly behind a flush finds an empty table.
  a_flush_then_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_opcode == mahs_pkg::OP_FLUSH)) ##1 (acc && (in_opcode == mahs_pkg::OP_LOOKUP))
      |-> ##4 !out_hit)
    else $error("hit right after a flush");

endmodule

bind mac_address_hash_set_top mahs_chk u_mahs_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_opcode       (in_opcode),
  .out_strobe      (out_strobe),
  .out_hit         (out_hit),
  .out_bucket_full (out_bucket_full)
);

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int BUCKETS     = mahs_pkg::BUCKETS_DEF;
  localparam int WAYS        = mahs_pkg::WAYS_DEF;
  localparam int TABLE_DEPTH = BUCKETS * WAYS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    mahs_pkg::op_t   op;
    mahs_pkg::addr_t mac;
    int unsigned     gap_pct;
    bit              drain_first;
  } mac_item_t;

  typedef struct {
    bit                         hit;
    bit                         bucket_full;
    logic [mahs_pkg::IDX_W-1:0] bucket_index;
  } hash_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [mahs_pkg::OPC_W-1:0]  in_opcode = mahs_pkg::OP_NOP;
  logic [mahs_pkg::ADDR_W-1:0] in_mac_addr = '0;
  logic                        out_strobe;
  logic                        out_hit;
  logic                        out_bucket_full;
  logic [mahs_pkg::IDX_W-1:0]  out_bucket_index;

  mac_item_t       pending_items[$];
  hash_result_t    expected_results[$];
  mahs_pkg::addr_t known_macs[$];
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count = 0;

  // Shadow copy of the table.
  mahs_pkg::addr_t shadow_mac[TABLE_DEPTH];
  bit              shadow_valid[TABLE_DEPTH];

  mac_address_hash_set_top #(
    .BUCKETS(BUCKETS),
    .WAYS(WAYS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_opcode(in_opcode),
    .in_mac_addr(in_mac_addr),
    .out_strobe(out_strobe),
    .out_hit(out_hit),
    .out_bucket_full(out_bucket_full),
    .out_bucket_index(out_bucket_index)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned bucket_of_mac(mahs_pkg::addr_t mac);
    int unsigned byte_sum;
    byte_sum = 0;
    for (int b = 0; b < mahs_pkg::NBYTES; b++) begin
      byte_sum += 32'(mac[8*b +: 8]);
    end
    return byte_sum % BUCKETS;
  endfunction

  // Applies one operation to the shadow table and returns the result it yields.
  function automatic hash_result_t predict_table_op(mahs_pkg::op_t op, mahs_pkg::addr_t mac);
    hash_result_t res;
    int unsigned  base;
    bit           placed;
    base = bucket_of_mac(mac) * WAYS;
    placed = 1'b0;
    res.hit = 1'b0;
    res.bucket_full = 1'b0;
    res.bucket_index = mahs_pkg::IDX_W'(bucket_of_mac(mac));
    case (op)
      mahs_pkg::OP_INSERT: begin
        for (int w = 0; w < WAYS; w++) begin
          if (!placed && !shadow_valid[base + w]) begin
            shadow_mac[base + w] = mac;
            shadow_valid[base + w] = 1'b1;
            placed = 1'b1;
          end
        end
        res.bucket_full = !placed;
      end
      mahs_pkg::OP_LOOKUP: begin
        for (int w = 0; w < WAYS; w++) begin
          if (shadow_valid[base + w] && shadow_mac[base + w] == mac) begin
            res.hit = 1'b1;
          end
        end
      end
      mahs_pkg::OP_FLUSH: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          shadow_valid[i] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic queue_op(mahs_pkg::op_t op, mahs_pkg::addr_t mac, int unsigned gap_pct,
                          bit drain_first = 1'b0);
    mac_item_t item;
    item.op = op;
    item.mac = mac;
    item.gap_pct = gap_pct;
    item.drain_first = drain_first;
    pending_items.push_back(item);
  endtask

  // Swapping two bytes keeps the byte sum, so the result lands in the same bucket.
  function automatic mahs_pkg::addr_t swap_two_bytes(mahs_pkg::addr_t mac);
    int unsigned i;
    int unsigned j;
    logic [7:0]  tmp;
    i = $urandom_range(mahs_pkg::NBYTES - 1);
    j = $urandom_range(mahs_pkg::NBYTES - 1);
    tmp = mac[8*i +: 8];
    mac[8*i +: 8] = mac[8*j +: 8];
    mac[8*j +: 8] = tmp;
    return mac;
  endfunction

  function automatic mahs_pkg::addr_t random_mac();
    return mahs_pkg::addr_t'({$urandom(), $urandom()});
  endfunction

  function automatic mahs_pkg::addr_t pick_known_mac();
    if (known_macs.size() == 0) begin
      return random_mac();
    end
    return known_macs[$urandom_range(known_macs.size() - 1)];
  endfunction

  // Mostly inserts and lookups, many on addresses already used, so buckets fill up and
  // lookups hit; byte swaps give misses that share a bucket with stored entries.
  task automatic queue_random_phase(int unsigned count, int unsigned gap_pct);
    int unsigned     roll;
    mahs_pkg::addr_t mac;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        case ($urandom_range(3))
          0, 1: mac = random_mac();
          2: mac = pick_known_mac();
          default: mac = swap_two_bytes(pick_known_mac());
        endcase
        known_macs.push_back(mac);
        queue_op(mahs_pkg::OP_INSERT, mac, gap_pct, n == 0);
      end else if (roll < 93) begin
        case ($urandom_range(3))
          0, 1: mac = pick_known_mac();
          2: mac = swap_two_bytes(pick_known_mac());
          default: mac = random_mac();
        endcase
        queue_op(mahs_pkg::OP_LOOKUP, mac, gap_pct, n == 0);
      end else if (roll < 97) begin
        queue_op(mahs_pkg::OP_FLUSH, random_mac(), gap_pct, n == 0);
      end else begin
        queue_op(mahs_pkg::OP_NOP, random_mac(), gap_pct, n == 0);
      end
    end
  endtask

  // Driver: a transfer happens at an edge where start is high and busy is low.
  always @(posedge clk) begin
    mac_item_t next_item;
    bit        offer;
    offer = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        expected_results.push_back(predict_table_op(mahs_pkg::op_t'(in_opcode), in_mac_addr));
      end
      if (pending_items.size() != 0) begin
        next_item = pending_items[0];
        if (next_item.drain_first && expected_results.size() != 0) begin
          offer = 1'b0;
        end else begin
          offer = ($urandom_range(99) >= next_item.gap_pct);
        end
      end
      if (offer) begin
        void'(pending_items.pop_front());
        in_opcode <= next_item.op;
        in_mac_addr <= next_item.mac;
      end
      start <= offer;
    end
  end

  // Monitor: each strobe is one result transfer, checked against the oldest prediction.
  always @(posedge clk) begin
    hash_result_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $error("result with no prediction pending: hit=%0d bucket_full=%0d bucket_index=%0d",
               out_hit, out_bucket_full, out_bucket_index);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_hit !== want.hit) begin
          $error("out_hit mismatch: expected %0d, actual %0d", want.hit, out_hit);
          mismatch_count++;
        end
        if (out_bucket_full !== want.bucket_full) begin
          $error("out_bucket_full mismatch: expected %0d, actual %0d",
                 want.bucket_full, out_bucket_full);
          mismatch_count++;
        end
        if (out_bucket_index !== want.bucket_index) begin
          $error("out_bucket_index mismatch: expected %0d, actual %0d",
                 want.bucket_index, out_bucket_index);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    mahs_pkg::addr_t mac_a;
    mahs_pkg::addr_t mac_b;
    mahs_pkg::addr_t mac_c;
    mahs_pkg::addr_t mac_d;
    mac_a = 48'h010203040506;
    mac_b = 48'h060504030201;
    mac_c = 48'h020103040506;
    mac_d = 48'h030201040506;

    // Directed: empty table, extreme addresses, a bucket filled past its ways
    // with a duplicate in it, a no-op, and a flush followed by reuse.
    queue_op(mahs_pkg::OP_LOOKUP, '0, 0);
    queue_op(mahs_pkg::OP_INSERT, '0, 0);
    queue_op(mahs_pkg::OP_INSERT, '1, 0);
    queue_op(mahs_pkg::OP_LOOKUP, '1, 0);
    queue_op(mahs_pkg::OP_LOOKUP, '0, 35);
    queue_op(mahs_pkg::OP_NOP, '1, 0);
    queue_op(mahs_pkg::OP_INSERT, mac_a, 0);
    queue_op(mahs_pkg::OP_INSERT, mac_a, 0);
    queue_op(mahs_pkg::OP_INSERT, mac_b, 35);
    queue_op(mahs_pkg::OP_INSERT, mac_c, 0);
    queue_op(mahs_pkg::OP_INSERT, mac_d, 0);
    queue_op(mahs_pkg::OP_LOOKUP, mac_d, 0);
    queue_op(mahs_pkg::OP_LOOKUP, mac_b, 35);
    queue_op(mahs_pkg::OP_FLUSH, '1, 0);
    queue_op(mahs_pkg::OP_LOOKUP, mac_a, 0);
    queue_op(mahs_pkg::OP_INSERT, mac_d, 0);
    queue_op(mahs_pkg::OP_LOOKUP, mac_d, 0);
    queue_op(mahs_pkg::OP_LOOKUP, '0, 0);
    known_macs.push_back(mac_a);
    known_macs.push_back(mac_d);

    queue_random_phase(570, 35);
    queue_random_phase(570, 77);
    queue_random_phase(560, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || start) begin
      @(posedge clk);
    end
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/mahs_pkg.sv
rtl/core/mac_address_hash_set_top.sv
rtl/core/mahs_chk.sv
sim/testbench.sv
